>>> rtl/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg: shared types and constants of the range prime finder
// Number widths, register indexes and the request/response bundles of the
// shared remainder unit.
// ----------------------------------------------------------------------------
package rpf_pkg;

    // Width of candidates, bounds and the prime count.
    localparam int NUM_W = 64;
    // A divisor never exceeds the square root of a candidate plus one odd step.
    localparam int DIV_W = (NUM_W + 1) / 2 + 1;
    // Running square of the divisor.
    localparam int SQ_W = 2 * DIV_W;
    // Bit counter of the remainder unit.
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;
    localparam int CFG_DATA_W = 64;

    // Reset values of the bounds.
    localparam logic [NUM_W-1:0] RANGE_LOW_RST  = NUM_W'(1);
    localparam logic [NUM_W-1:0] RANGE_HIGH_RST = NUM_W'(100);

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_rsp;

endpackage

>>> rtl/range_prime_finder.sv
// ----------------------------------------------------------------------------
// range_prime_finder: trial-division prime scan over a configured range
// Returns, for each request, the next prime between range_low and
// range_high, the running count of primes and a done flag.
// ----------------------------------------------------------------------------
// Each request walks the candidates from where the previous request stopped
// (or from range_low when restart is set) and returns the next prime, the
// number of primes found since the last restart, and a done flag once no
// prime is left in the range; after that every request repeats value 0,
// the final count and done. Candidates below two are never prime, two is
// prime and other even numbers are rejected in the check state. An odd
// candidate is tested with odd divisors from three while the divisor squared
// does not exceed it; every divisor costs one pass of the shared remainder
// unit plus the test and divide states that sequence it, so the time a
// request takes depends on the data and on the receiver: a check for every
// candidate it visits, a remainder pass per trial divisor, a final square
// compare when an odd candidate turns out prime, and the posting of the
// result, which waits while the output register is still held downstream.
// The block takes one request at a time and drives o_stall for the whole
// search; a finished result sits in the output register, so the next request
// may be accepted while it waits downstream. The user must write the bounds
// through the configuration port only while the block is idle; the block
// does not enforce this. A new range_low takes effect at the next restart,
// a new range_high at once.
module range_prime_finder import rpf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request channel.
    input  logic                  i_valid,
    input  logic                  i_restart,
    output logic                  o_stall,
    // Result channel.
    output logic                  o_valid,
    output logic [NUM_W-1:0]      o_prime_value,
    output logic [NUM_W-1:0]      o_prime_count,
    output logic                  o_done_res,
    input  logic                  i_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TEST,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    // Bounds.
    logic [NUM_W-1:0] r_low, r_high;

    // Scan state: next candidate, primes found, range used up.
    logic [NUM_W-1:0] r_cand, n_cand;
    logic [NUM_W-1:0] r_cnt, n_cnt;
    logic             r_fin, n_fin;

    // Trial divisor and its square.
    logic [DIV_W-1:0] r_d, n_d;
    logic [SQ_W-1:0]  r_sq, n_sq;

    // Result waiting for the output register.
    logic [NUM_W-1:0] r_res_value, n_res_value;
    logic             r_res_done, n_res_done;

    // Output register.
    logic             r_ovalid, n_ovalid;
    logic [NUM_W-1:0] r_oval, n_oval;
    logic [NUM_W-1:0] r_ocnt, n_ocnt;
    logic             r_odone, n_odone;

    t_rem_req rem_req;
    t_rem_rsp rem_rsp;

    logic cand_last;
    logic found_prime;
    logic found_comp;
    logic in_accept;

    rpf_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    assign in_accept = i_valid && (r_state == S_IDLE);
    // The current candidate is the last one the scan may look at.
    assign cand_last = (r_cand == r_high) || (r_cand == NUM_MAX);

    always_comb begin
        n_state     = r_state;
        n_cand      = r_cand;
        n_cnt       = r_cnt;
        n_fin       = r_fin;
        n_d         = r_d;
        n_sq        = r_sq;
        n_res_value = r_res_value;
        n_res_done  = r_res_done;
        found_prime = 1'b0;
        found_comp  = 1'b0;

        rem_req.start    = 1'b0;
        rem_req.dividend = r_cand;
        rem_req.divisor  = r_d;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_restart) begin
                        n_cand  = r_low;
                        n_cnt   = '0;
                        n_fin   = 1'b0;
                        n_state = S_CHECK;
                    end else if (r_fin) begin
                        n_res_value = '0;
                        n_res_done  = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_cand > r_high) begin
                    n_fin       = 1'b1;
                    n_res_value = '0;
                    n_res_done  = 1'b1;
                    n_state     = S_OUT;
                end else if (r_cand < NUM_W'(2)) begin
                    found_comp = 1'b1;
                end else if (r_cand == NUM_W'(2)) begin
                    found_prime = 1'b1;
                end else if (!r_cand[0]) begin
                    found_comp = 1'b1;
                end else begin
                    n_d     = DIV_W'(3);
                    n_sq    = SQ_W'(9);
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (r_sq > SQ_W'(r_cand)) begin
                    found_prime = 1'b1;
                end else begin
                    rem_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_rsp.done) begin
                    if (rem_rsp.zero) begin
                        found_comp = 1'b1;
                    end else begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        n_sq    = r_sq + SQ_W'({r_d, 2'b00}) + SQ_W'(4);
                        n_d     = r_d + DIV_W'(2);
                        n_state = S_TEST;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A prime ends the request. The scan moves past it unless it sits at
        // the top of the number range, where the scan stops until the next restart.
        if (found_prime) begin
            n_cnt       = r_cnt + NUM_W'(1);
            n_fin       = (r_cand == NUM_MAX);
            n_cand      = (r_cand == NUM_MAX) ? r_cand : r_cand + NUM_W'(1);
            n_res_value = r_cand;
            n_res_done  = 1'b0;
            n_state     = S_OUT;
        end

        // A composite moves on to the next candidate, or ends the scan.
        if (found_comp) begin
            if (cand_last) begin
                n_fin       = 1'b1;
                n_res_value = '0;
                n_res_done  = 1'b1;
                n_state     = S_OUT;
            end else begin
                n_cand  = r_cand + NUM_W'(1);
                n_state = S_CHECK;
            end
        end
    end

    // Output register: loaded when the result is posted, emptied when taken.
    always_comb begin
        n_ovalid = r_ovalid;
        n_oval   = r_oval;
        n_ocnt   = r_ocnt;
        n_odone  = r_odone;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        if ((r_state == S_OUT) && (!r_ovalid || !i_stall)) begin
            n_ovalid = 1'b1;
            n_oval   = r_res_value;
            n_ocnt   = r_cnt;
            n_odone  = r_res_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_low    <= RANGE_LOW_RST;
            r_high   <= RANGE_HIGH_RST;
            r_cand   <= RANGE_LOW_RST;
            r_cnt    <= '0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cand   <= n_cand;
            r_cnt    <= n_cnt;
            r_fin    <= n_fin;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RANGE_LOW:  r_low  <= NUM_W'(i_cfg_data);
                    REG_RANGE_HIGH: r_high <= NUM_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
        r_d         <= n_d;
        r_sq        <= n_sq;
        r_res_value <= n_res_value;
        r_res_done  <= n_res_done;
        r_oval      <= n_oval;
        r_ocnt      <= n_ocnt;
        r_odone     <= n_odone;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_prime_value = r_oval;
    assign o_prime_count = r_ocnt;
    assign o_done_res    = r_odone;

endmodule

>>> rtl/rpf_rem_unit.sv
// ----------------------------------------------------------------------------
// rpf_rem_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; reports whether the
// remainder is zero.
// ----------------------------------------------------------------------------
module rpf_rem_unit import rpf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic             r_zero;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W-1:0] r_rem;

    logic [DIV_W:0]   shifted;
    logic [DIV_W-1:0] n_rem;

    // The partial remainder stays below the divisor, so one compare and
    // subtract per bit is enough.
    always_comb begin
        shifted = {r_rem, r_dvd[NUM_W-1]};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = DIV_W'(shifted - {1'b0, r_dvs});
        end else begin
            n_rem = shifted[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_zero <= (n_rem == '0);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = r_zero;

endmodule

>>> rtl/rpf_checker.sv
// ----------------------------------------------------------------------------
// rpf_checker: port-level checks of the range prime finder
// Watches the top-level ports and flags results and handshakes that the
// block can never produce.
// ----------------------------------------------------------------------------
module rpf_checker import rpf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  logic                  o_valid,
    input  logic [NUM_W-1:0]      o_prime_value,
    input  logic [NUM_W-1:0]      o_prime_count,
    input  logic                  o_done_res,
    input  logic                  i_stall
);

    // A done result carries no prime.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_prime_value == '0)
        else $error("done result with a nonzero prime value");

    // A reported prime is two or odd, and never one.
    a_prime_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |->
            (o_prime_value == NUM_W'(2) || o_prime_value[0]) &&
            o_prime_value != NUM_W'(1))
        else $error("reported prime is even or below two");

    // Once a request is taken the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after taking a request");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=>
            o_valid && $stable(o_prime_value) && $stable(o_prime_count) &&
            $stable(o_done_res))
        else $error("stalled result changed");

endmodule

bind range_prime_finder rpf_checker u_rpf_checker (.*);

>>> bench/range_prime_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_prime_finder_tb: self-checking bench for the trial-division prime scan
// Drives scan requests and bound writes into the block and predicts every
// result with a behavioral scan model kept in step with the accepted requests.
// Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module range_prime_finder_tb;
    import rpf_pkg::*;

    // One predicted or observed result of a request.
    typedef struct packed {
        logic [NUM_W-1:0] value;
        logic [NUM_W-1:0] count;
        logic             done;
    } prime_result_t;

    // Random requests after the directed part; idling stops for the last
    // stretch of them so the tail runs at full rate.
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_TAIL    = 100;
    // Cycles without any accepted request or result before the run is
    // declared hung. The slowest request scans a few dozen candidates below
    // about 600, each costing at most a dozen divisor passes.
    localparam int QUIET_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  i_restart;
    logic                  o_stall;
    logic                  o_valid;
    logic [NUM_W-1:0]      o_prime_value;
    logic [NUM_W-1:0]      o_prime_count;
    logic                  o_done_res;
    logic                  i_stall;

    range_prime_finder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_restart     (i_restart),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_prime_value (o_prime_value),
        .o_prime_count (o_prime_count),
        .o_done_res    (o_done_res),
        .i_stall       (i_stall)
    );

    // Scan model state: its own copy of the bounds and of the scan position.
    logic [NUM_W-1:0] bound_low;
    logic [NUM_W-1:0] bound_high;
    logic [NUM_W-1:0] scan_pos;
    logic [NUM_W-1:0] prime_tally;
    logic             scan_over;

    // Results still owed by the block, oldest first.
    prime_result_t expected_primes[$];

    bit sender_idles;
    bit receiver_idles;
    int failures;
    int random_sent;
    int requests_sent;
    int restarts_sent;
    int primes_seen;
    int done_seen;
    int bound_writes;
    int quiet_cycles;

    always #2 i_clk = ~i_clk;

    // Plain trial division: two is prime, other even numbers and anything
    // below two are not, odd numbers are tried with odd divisors while the
    // divisor squared stays within the number.
    function automatic bit is_prime_number(input logic [NUM_W-1:0] n);
        logic [NUM_W-1:0] d;
        if (n < 2)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the scan model by one request and returns the result that the
    // block owes for it. A restart takes effect before the search. The scan
    // stops at the upper bound or at the top of the number range without
    // wrapping; the request that finds the last prime still reports not done,
    // and only the following one reports done.
    function automatic prime_result_t advance_scan(input bit restart);
        prime_result_t r;
        logic [NUM_W-1:0] c;
        if (restart) begin
            scan_pos    = bound_low;
            prime_tally = '0;
            scan_over   = 1'b0;
        end
        while (!scan_over) begin
            c = scan_pos;
            if (c > bound_high) begin
                scan_over = 1'b1;
                break;
            end
            if (c == bound_high || c == NUM_MAX)
                scan_over = 1'b1;
            else
                scan_pos = c + 1;
            if (is_prime_number(c)) begin
                prime_tally = prime_tally + 1;
                if (scan_over)
                    scan_pos = c;
                scan_over = 1'b0;
                if (c == bound_high || c == NUM_MAX) begin
                    // Park just past the range so the next request reports done.
                    scan_pos = (bound_high < NUM_MAX) ? bound_high + 1 : c;
                    if (c == NUM_MAX)
                        scan_over = 1'b1;
                end
                r.value = c;
                r.count = prime_tally;
                r.done  = 1'b0;
                return r;
            end
        end
        r.value = '0;
        r.count = prime_tally;
        r.done  = 1'b1;
        return r;
    endfunction

    // Writes one bound register; the block is idle whenever this is called.
    task automatic write_bound(input logic [CFG_IDX_W-1:0] index,
                               input logic [NUM_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(posedge i_clk);
        if (index == REG_RANGE_LOW)
            bound_low = value;
        else
            bound_high = value;
        bound_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Presents one request, optionally after a random idle burst, and holds
    // it until the block takes it. The prediction is made at the accepting
    // edge so it sees exactly the bounds the block sees.
    task automatic send_request(input bit restart);
        int gap;
        gap = (sender_idles && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid   = 1'b0;
            i_restart = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_restart = restart;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        expected_primes.push_back(advance_scan(restart));
        requests_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // Drops the request line and waits until every owed result has arrived,
    // which leaves the block idle for bound writes.
    task automatic pause_until_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_primes.size() != 0)
            @(negedge i_clk);
    endtask

    // Right after reset the bounds are 1 and 100, and the scan may start
    // without a restart.
    task automatic test_reset_bounds();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        pause_until_drained();
    endtask

    // Ranges holding only zero, one and two: the prime at the upper bound is
    // reported as not done, then done repeats with the final count.
    task automatic test_tiny_ranges();
        write_bound(REG_RANGE_LOW, '0);
        write_bound(REG_RANGE_HIGH, NUM_W'(2));
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        pause_until_drained();
        write_bound(REG_RANGE_LOW, NUM_W'(2));
        send_request(1'b1);
        send_request(1'b0);
        pause_until_drained();
        write_bound(REG_RANGE_LOW, '0);
        write_bound(REG_RANGE_HIGH, NUM_W'(1));
        send_request(1'b1);
        pause_until_drained();
    endtask

    // Low bound above the high bound, including all-ones against zero.
    task automatic test_empty_range();
        write_bound(REG_RANGE_LOW, NUM_W'(50));
        write_bound(REG_RANGE_HIGH, NUM_W'(10));
        send_request(1'b1);
        pause_until_drained();
        write_bound(REG_RANGE_LOW, NUM_MAX);
        write_bound(REG_RANGE_HIGH, '0);
        send_request(1'b1);
        pause_until_drained();
    endtask

    // A scan that runs into the largest representable number must stop there.
    task automatic test_top_of_range();
        write_bound(REG_RANGE_LOW, NUM_MAX - 1);
        write_bound(REG_RANGE_HIGH, NUM_MAX);
        send_request(1'b1);
        send_request(1'b0);
        pause_until_drained();
    endtask

    // Bounds rewritten under a running scan: a lower high bound ends it at
    // once, raising it again does not revive it, and a new low bound only
    // counts from the next restart.
    task automatic test_bound_change();
        write_bound(REG_RANGE_LOW, NUM_W'(20));
        write_bound(REG_RANGE_HIGH, NUM_W'(40));
        send_request(1'b1);
        send_request(1'b0);
        pause_until_drained();
        write_bound(REG_RANGE_HIGH, NUM_W'(30));
        send_request(1'b0);
        pause_until_drained();
        write_bound(REG_RANGE_HIGH, NUM_W'(60));
        write_bound(REG_RANGE_LOW, NUM_W'(41));
        send_request(1'b0);
        send_request(1'b1);
        pause_until_drained();
    endtask

    // A restart in the middle of a scan clears the count before searching.
    task automatic test_restart_midscan();
        write_bound(REG_RANGE_LOW, NUM_W'(1));
        write_bound(REG_RANGE_HIGH, NUM_W'(100));
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        pause_until_drained();
    endtask

    // Random phases: pick new bounds, then run a burst of requests that
    // mostly continue the scan. Ranges stay small because every trial divisor
    // costs the block a full remainder pass; the empty and top-of-range kinds
    // carry the large values without ever scanning them.
    task automatic test_random_scans();
        int kind;
        int phase_len;
        bit fresh;
        logic [NUM_W-1:0] a;
        logic [NUM_W-1:0] b;
        logic [NUM_W-1:0] lo;
        while (random_sent < RANDOM_ITEMS) begin
            kind  = $urandom_range(0, 19);
            fresh = 1'b1;
            if (kind == 0) begin
                a = {$urandom, $urandom};
                b = {$urandom, $urandom};
                if (a == b)
                    b = ~a;
                write_bound(REG_RANGE_LOW, (a > b) ? a : b);
                write_bound(REG_RANGE_HIGH, (a > b) ? b : a);
            end else if (kind == 1) begin
                write_bound(REG_RANGE_LOW, NUM_MAX - $urandom_range(0, 1));
                write_bound(REG_RANGE_HIGH, NUM_MAX);
            end else if (kind == 2) begin
                // Move only the upper bound and keep scanning from where we are.
                write_bound(REG_RANGE_HIGH, NUM_W'($urandom_range(0, 600)));
                fresh = 1'b0;
            end else if (kind == 3) begin
                write_bound(REG_RANGE_LOW, NUM_W'($urandom_range(0, 2)));
                write_bound(REG_RANGE_HIGH, NUM_W'($urandom_range(0, 6)));
            end else begin
                lo = NUM_W'($urandom_range(0, 400));
                write_bound(REG_RANGE_LOW, lo);
                write_bound(REG_RANGE_HIGH, lo + $urandom_range(0, 120));
            end
            phase_len = $urandom_range(1, 40);
            for (int k = 0; k < phase_len; k++) begin
                if (random_sent >= RANDOM_ITEMS - CALM_TAIL) begin
                    sender_idles   = 1'b0;
                    receiver_idles = 1'b0;
                end
                send_request((k == 0) ? fresh : ($urandom_range(0, 14) == 0));
                random_sent++;
            end
            pause_until_drained();
        end
    endtask

    // Receiver: random stall bursts, changed at falling edges.
    always begin
        @(negedge i_clk);
        if (receiver_idles && $urandom_range(0, 5) == 0) begin
            i_stall = 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            i_stall = 1'b0;
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // prediction, one field at a time.
    always @(posedge i_clk) begin
        prime_result_t want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (expected_primes.size() == 0) begin
                $error("unexpected result: prime_value %0d prime_count %0d done_res %0b",
                       o_prime_value, o_prime_count, o_done_res);
                failures++;
            end else begin
                want = expected_primes.pop_front();
                if (o_prime_value !== want.value) begin
                    $error("prime_value: expected %0d, got %0d", want.value, o_prime_value);
                    failures++;
                end
                if (o_prime_count !== want.count) begin
                    $error("prime_count: expected %0d, got %0d", want.count, o_prime_count);
                    failures++;
                end
                if (o_done_res !== want.done) begin
                    $error("done_res: expected %0b, got %0b", want.done, o_done_res);
                    failures++;
                end
                if (want.done)
                    done_seen++;
                else
                    primes_seen++;
            end
        end
    end

    // Watchdog: a stretch with no request and no result taken means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("range_prime_finder: mismatch");
                $finish;
            end
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_RANGE_LOW;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_restart      = 1'b0;
        i_stall        = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        failures       = 0;
        random_sent    = 0;
        requests_sent  = 0;
        restarts_sent  = 0;
        primes_seen    = 0;
        done_seen      = 0;
        bound_writes   = 0;
        quiet_cycles   = 0;

        // The model starts from the block's documented reset state.
        bound_low   = RANGE_LOW_RST;
        bound_high  = RANGE_HIGH_RST;
        scan_pos    = RANGE_LOW_RST;
        prime_tally = '0;
        scan_over   = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_bounds();
        test_tiny_ranges();
        test_empty_range();
        test_top_of_range();
        test_bound_change();
        test_restart_midscan();
        test_random_scans();

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d with restart) across %0d bound writes.",
                 requests_sent, restarts_sent, bound_writes);
        $display("Checked %0d prime results and %0d end-of-range results.",
                 primes_seen, done_seen);
        if (failures == 0 && expected_primes.size() == 0) begin
            $display("range_prime_finder: match");
        end else begin
            $display("range_prime_finder: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/rpf_pkg.sv
rtl/rpf_rem_unit.sv
rtl/range_prime_finder.sv
rtl/rpf_checker.sv
bench/range_prime_finder_tb.sv
